>>> rtl/split_tree_neighbors_assert.svh
// Assertion macros for the split tree neighbor block.
// Used by rtl/split_tree_neighbors.sv; needs no package.
`ifndef SPLIT_TREE_NEIGHBORS_ASSERT_SVH
`define SPLIT_TREE_NEIGHBORS_ASSERT_SVH

// Checked on the rising clock edge and ignored while reset is held low.
`define STN_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define STN_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/stn_pkg.sv
// Shared widths, register indexes and the split unit result type.
// Used by rtl/stn_split_unit.sv and rtl/split_tree_neighbors.sv.
package stn_pkg;

    localparam int RANK_W  = 6;
    localparam int SIZE_W  = 7;
    localparam int RATIO_W = 17;
    localparam int IDX_W   = 2;
    localparam int FRAC_W  = 16;

    localparam logic [IDX_W-1:0] CFG_GROUP_SIZE  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_SPLIT_RATIO = 2'd1;

    // One split of the current segment.
    typedef struct packed {
        logic [SIZE_W-1:0] pbig;
        logic [RANK_W-1:0] child_id;
        logic [SIZE_W-1:0] child_blocks;
        logic [RANK_W-1:0] parent_id;
        logic              is_head;
        logic              is_child;
        logic [SIZE_W-1:0] next_size;
        logic [RANK_W-1:0] next_relpos;
    } t_step_res;

endpackage

>>> rtl/stn_split_unit.sv
// Shared split unit: split point, neighbor ranks and the next segment.
// Depends on stn_pkg.
module stn_split_unit (
    input  logic [stn_pkg::SIZE_W-1:0]  i_size,
    input  logic [stn_pkg::RANK_W-1:0]  i_relpos,
    input  logic [stn_pkg::RANK_W-1:0]  i_rank,
    input  logic [stn_pkg::SIZE_W-1:0]  i_group,
    input  logic [stn_pkg::RATIO_W-1:0] i_ratio,
    output stn_pkg::t_step_res          o_res
);

    localparam int PROD_W = stn_pkg::RATIO_W + stn_pkg::SIZE_W;
    localparam int RAW_W  = PROD_W - stn_pkg::FRAC_W;

    logic [PROD_W-1:0]          prod;
    logic [RAW_W-1:0]           raw;
    logic [stn_pkg::SIZE_W-1:0] size_m1;
    logic [stn_pkg::SIZE_W-1:0] pbig;
    logic [stn_pkg::SIZE_W-1:0] upper;
    logic [stn_pkg::SIZE_W-1:0] csum;
    logic [stn_pkg::SIZE_W:0]   pdiff;
    logic [stn_pkg::SIZE_W:0]   pwrap;
    logic                       go_low;

    always_comb begin
        prod    = PROD_W'(i_ratio) * PROD_W'(i_size);
        raw     = prod[PROD_W-1:stn_pkg::FRAC_W];
        size_m1 = i_size - 7'd1;
        if (raw > RAW_W'(size_m1)) begin
            pbig = size_m1;
        end else begin
            pbig = raw[stn_pkg::SIZE_W-1:0];
        end
        if (pbig == '0) begin
            pbig = 7'd1;
        end
        upper = i_size - pbig;

        // Both sums stay within one group size of the valid range.
        csum = {1'b0, i_rank} + pbig;
        if (csum >= i_group) begin
            csum = csum - i_group;
        end
        pdiff = {2'b00, i_rank} - {1'b0, pbig};
        pwrap = pdiff[stn_pkg::SIZE_W] ? (pdiff + {1'b0, i_group}) : pdiff;

        go_low = pbig > {1'b0, i_relpos};

        o_res.pbig         = pbig;
        o_res.child_id     = csum[stn_pkg::RANK_W-1:0];
        o_res.child_blocks = upper;
        o_res.parent_id    = pwrap[stn_pkg::RANK_W-1:0];
        o_res.is_head      = (i_relpos == '0);
        o_res.is_child     = ({1'b0, i_relpos} == pbig);
        o_res.next_size    = go_low ? pbig : upper;
        o_res.next_relpos  = go_low ? i_relpos : (i_relpos - pbig[stn_pkg::RANK_W-1:0]);
    end

endmodule

>>> rtl/split_tree_neighbors.sv
// Top level of the split tree neighbor block: sequencer, registers, ports.
// Depends on stn_pkg, stn_split_unit and split_tree_neighbors_assert.svh.
//
// A query for one rank is loaded, then the current segment is split one step
// at a time through the single shared split unit (multiply by the ratio,
// clip, wrap the ranks), and the final item follows. The walk is longest
// for ratios near zero or near one, and shorter for ratios near one half,
// where the segment halves at each split. Each child item and the final
// item leave through one output register; a split that yields a child waits
// while that register is full and stalled. No new query is taken until the
// final item of the current one is in the output register. A rank not below
// the group size yields only a final item with the error flag. Configuration
// writes are always ready.
`include "split_tree_neighbors_assert.svh"

module split_tree_neighbors #(
    parameter int MAX_GROUP = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [stn_pkg::RANK_W-1:0]  i_my_rank,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [stn_pkg::RANK_W-1:0]  o_child_id,
    output logic [stn_pkg::SIZE_W-1:0]  o_child_blocks,
    output logic [stn_pkg::RANK_W-1:0]  o_parent_id,
    output logic                        o_has_parent,
    output logic [stn_pkg::SIZE_W-1:0]  o_own_blocks,
    output logic                        o_rank_error,
    output logic                        o_last,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [stn_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [stn_pkg::RATIO_W-1:0] i_cfg_data
);

    localparam logic [stn_pkg::SIZE_W-1:0] MAX_G = stn_pkg::SIZE_W'(MAX_GROUP);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state                      r_state, n_state;
    logic [stn_pkg::SIZE_W-1:0]  r_group_size;
    logic [stn_pkg::RATIO_W-1:0] r_split_ratio;
    logic [stn_pkg::SIZE_W-1:0]  r_size, n_size;
    logic [stn_pkg::RANK_W-1:0]  r_relpos, n_relpos;
    logic [stn_pkg::RANK_W-1:0]  r_rank, n_rank;
    logic [stn_pkg::SIZE_W-1:0]  r_g, n_g;
    logic [stn_pkg::RANK_W-1:0]  r_parent, n_parent;
    logic                        r_seen, n_seen;
    logic [stn_pkg::SIZE_W-1:0]  r_recv, n_recv;
    logic                        r_err, n_err;
    logic                        r_out_valid, n_out_valid;
    logic                        load_child, load_final;

    logic [stn_pkg::RANK_W-1:0]  r_child_id;
    logic [stn_pkg::SIZE_W-1:0]  r_child_blocks;
    logic [stn_pkg::RANK_W-1:0]  r_parent_id;
    logic                        r_has_parent;
    logic [stn_pkg::SIZE_W-1:0]  r_own_blocks;
    logic                        r_rank_error;
    logic                        r_last;

    stn_pkg::t_step_res          step;
    logic                        in_acc;
    logic                        out_free;
    logic                        done;
    logic [stn_pkg::SIZE_W-1:0]  g_sat;

    stn_split_unit u_split (
        .i_size   (r_size),
        .i_relpos (r_relpos),
        .i_rank   (r_rank),
        .i_group  (r_g),
        .i_ratio  (r_split_ratio),
        .o_res    (step)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign done        = (r_size <= 7'd1);

    always_comb begin
        if (r_group_size == '0) begin
            g_sat = 7'd1;
        end else if (r_group_size > MAX_G) begin
            g_sat = MAX_G;
        end else begin
            g_sat = r_group_size;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_size      = r_size;
        n_relpos    = r_relpos;
        n_rank      = r_rank;
        n_g         = r_g;
        n_parent    = r_parent;
        n_seen      = r_seen;
        n_recv      = r_recv;
        n_err       = r_err;
        n_out_valid = r_out_valid && i_out_stall;
        load_child  = 1'b0;
        load_final  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_rank   = i_my_rank;
                    n_g      = g_sat;
                    n_parent = '0;
                    n_seen   = 1'b0;
                    n_recv   = '0;
                    n_state  = S_RUN;
                    n_relpos = i_my_rank;
                    if ({1'b0, i_my_rank} >= g_sat) begin
                        // Size zero sends the sequencer straight to the final item.
                        n_err  = 1'b1;
                        n_size = '0;
                    end else begin
                        n_err  = 1'b0;
                        n_size = g_sat;
                    end
                end
            end
            S_RUN: begin
                if (done) begin
                    if (out_free) begin
                        load_final  = 1'b1;
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else if (!step.is_head || out_free) begin
                    if (step.is_head) begin
                        load_child  = 1'b1;
                        n_out_valid = 1'b1;
                    end
                    if (step.is_child) begin
                        n_parent = step.parent_id;
                        n_seen   = 1'b1;
                        n_recv   = step.child_blocks;
                    end
                    n_size   = step.next_size;
                    n_relpos = step.next_relpos;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_group_size  <= 7'd64;
            r_split_ratio <= 17'd32768;
            r_size        <= '0;
            r_relpos      <= '0;
            r_rank        <= '0;
            r_g           <= '0;
            r_parent      <= '0;
            r_seen        <= 1'b0;
            r_recv        <= '0;
            r_err         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_size      <= n_size;
            r_relpos    <= n_relpos;
            r_rank      <= n_rank;
            r_g         <= n_g;
            r_parent    <= n_parent;
            r_seen      <= n_seen;
            r_recv      <= n_recv;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    stn_pkg::CFG_GROUP_SIZE: begin
                        r_group_size <= i_cfg_data[stn_pkg::SIZE_W-1:0];
                    end
                    stn_pkg::CFG_SPLIT_RATIO: begin
                        r_split_ratio <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_child) begin
            r_child_id     <= step.child_id;
            r_child_blocks <= step.child_blocks;
            r_parent_id    <= '0;
            r_has_parent   <= 1'b0;
            r_own_blocks   <= '0;
            r_rank_error   <= 1'b0;
            r_last         <= 1'b0;
        end else if (load_final) begin
            r_child_id     <= '0;
            r_child_blocks <= '0;
            r_parent_id    <= r_parent;
            r_has_parent   <= r_seen;
            r_own_blocks   <= r_recv;
            r_rank_error   <= r_err;
            r_last         <= 1'b1;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_child_id     = r_child_id;
    assign o_child_blocks = r_child_blocks;
    assign o_parent_id    = r_parent_id;
    assign o_has_parent   = r_has_parent;
    assign o_own_blocks   = r_own_blocks;
    assign o_rank_error   = r_rank_error;
    assign o_last         = r_last;

    `STN_ASSERT(a_accept_runs, i_clk, i_rst_n, in_acc |=> (r_state == S_RUN), "query not started")
    `STN_ASSERT(a_pos_in_seg, i_clk, i_rst_n,
                ((r_state == S_RUN) && !r_err) |-> ({1'b0, r_relpos} < r_size),
                "position outside segment")
    `STN_ASSERT(a_seg_bound, i_clk, i_rst_n,
                ((r_state == S_RUN) && !r_err) |-> ((r_size <= r_g) && (r_size != '0)),
                "segment size out of range")
    `STN_ASSERT(a_final_idle, i_clk, i_rst_n,
                load_final |=> ((r_state == S_IDLE) && r_out_valid && r_last),
                "final item not delivered")

endmodule

>>> tb/sv/split_tree_neighbors_checker.sv
`timescale 1ns / 1ps
// Checker for split_tree_neighbors: watches the query, result and register channels,
// predicts every neighbor item of a query and compares it with the block's output.
// Depends on stn_pkg for widths and register indexes.
module split_tree_neighbors_checker #(
    parameter int MAX_GROUP = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic [stn_pkg::RANK_W-1:0]  i_my_rank,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [stn_pkg::RANK_W-1:0]  i_child_id,
    input  logic [stn_pkg::SIZE_W-1:0]  i_child_blocks,
    input  logic [stn_pkg::RANK_W-1:0]  i_parent_id,
    input  logic                        i_has_parent,
    input  logic [stn_pkg::SIZE_W-1:0]  i_own_blocks,
    input  logic                        i_rank_error,
    input  logic                        i_last,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [stn_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [stn_pkg::RATIO_W-1:0] i_cfg_data,
    output int                          o_pending,
    output int                          o_errors
);

    typedef struct packed {
        logic [stn_pkg::RANK_W-1:0] child_id;
        logic [stn_pkg::SIZE_W-1:0] child_blocks;
        logic [stn_pkg::RANK_W-1:0] parent_id;
        logic                       has_parent;
        logic [stn_pkg::SIZE_W-1:0] own_blocks;
        logic                       rank_error;
        logic                       last;
    } t_neighbor;

    t_neighbor neighbor_q[$];

    logic [stn_pkg::SIZE_W-1:0]  group_reg;
    logic [stn_pkg::RATIO_W-1:0] ratio_reg;

    // Working registers of the split walk; they keep their values after a query.
    logic [stn_pkg::SIZE_W-1:0] seg_size;
    logic [stn_pkg::RANK_W-1:0] seg_pos;
    logic [stn_pkg::RANK_W-1:0] parent_r;
    logic                       parent_found;
    logic [stn_pkg::SIZE_W-1:0] recv_blocks;

    function automatic string show(input t_neighbor n);
        return $sformatf("child=%0d blocks=%0d parent=%0d has_parent=%0b own=%0d err=%0b last=%0b",
                         n.child_id, n.child_blocks, n.parent_id, n.has_parent,
                         n.own_blocks, n.rank_error, n.last);
    endfunction

    // Walks the repeated split for one rank and queues the child items and the final item.
    function automatic void walk_split_tree(input logic [stn_pkg::RANK_W-1:0] rank);
        int        g;
        int        p;
        int        pbig;
        int        found;
        t_neighbor res;
        g = int'(group_reg);
        if (g < 1)
            g = 1;
        if (g > MAX_GROUP)
            g = MAX_GROUP;
        res = '0;
        if (int'(rank) >= g) begin
            res.rank_error = 1'b1;
            res.last       = 1'b1;
            neighbor_q.push_back(res);
            return;
        end
        seg_size     = stn_pkg::SIZE_W'(g);
        seg_pos      = rank;
        parent_r     = '0;
        parent_found = 1'b0;
        recv_blocks  = '0;
        found        = 0;
        while (seg_size > 1 && found < MAX_GROUP - 1) begin
            p    = int'(seg_size);
            pbig = (int'(ratio_reg) * p) >>> stn_pkg::FRAC_W;
            if (pbig > p - 1)
                pbig = p - 1;
            if (pbig < 1)
                pbig = 1;
            if (seg_pos == 0) begin
                res              = '0;
                res.child_id     = stn_pkg::RANK_W'((int'(rank) + pbig) % g);
                res.child_blocks = stn_pkg::SIZE_W'(p - pbig);
                neighbor_q.push_back(res);
                found++;
            end
            if (int'(seg_pos) == pbig) begin
                parent_r     = stn_pkg::RANK_W'((int'(rank) + g - pbig) % g);
                parent_found = 1'b1;
                recv_blocks  = stn_pkg::SIZE_W'(p - pbig);
            end
            if (pbig > int'(seg_pos)) begin
                seg_size = stn_pkg::SIZE_W'(pbig);
            end else begin
                seg_size = stn_pkg::SIZE_W'(p - pbig);
                seg_pos  = stn_pkg::RANK_W'(int'(seg_pos) - pbig);
            end
        end
        res            = '0;
        res.parent_id  = parent_r;
        res.has_parent = parent_found;
        res.own_blocks = recv_blocks;
        res.last       = 1'b1;
        neighbor_q.push_back(res);
    endfunction

    always @(posedge i_clk) begin : watch
        t_neighbor got;
        t_neighbor want;
        if (!i_rst_n) begin
            group_reg    = stn_pkg::SIZE_W'(64);
            ratio_reg    = stn_pkg::RATIO_W'(32768);
            seg_size     = '0;
            seg_pos      = '0;
            parent_r     = '0;
            parent_found = 1'b0;
            recv_blocks  = '0;
            neighbor_q.delete();
            o_pending    = 0;
            o_errors     = 0;
        end else begin
            // Results are matched before a new query is queued at the same edge.
            if (i_out_valid && !i_out_stall) begin
                got.child_id     = i_child_id;
                got.child_blocks = i_child_blocks;
                got.parent_id    = i_parent_id;
                got.has_parent   = i_has_parent;
                got.own_blocks   = i_own_blocks;
                got.rank_error   = i_rank_error;
                got.last         = i_last;
                if (neighbor_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("%0t: unexpected item: %s", $realtime, show(got));
                end else begin
                    want = neighbor_q.pop_front();
                    if (got !== want) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("%0t: item differs\n  expected %s\n  actual   %s",
                                     $realtime, show(want), show(got));
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == stn_pkg::CFG_GROUP_SIZE)
                    group_reg = i_cfg_data[stn_pkg::SIZE_W-1:0];
                else if (i_cfg_index == stn_pkg::CFG_SPLIT_RATIO)
                    ratio_reg = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall)
                walk_split_tree(i_my_rank);
            o_pending = neighbor_q.size();
        end
    end

endmodule

>>> tb/sv/tb_split_tree_neighbors.sv
`timescale 1ns / 1ps
// Top of the split_tree_neighbors testbench: clock, reset, queries, register writes and
// output stalls, with the verdict. Depends on stn_pkg and split_tree_neighbors_checker.
module tb_split_tree_neighbors;

    localparam int MAX_GROUP = 64;
    localparam int QUERY_TARGET = 430;
    localparam int DRAIN_CYCLES = 80;
    localparam logic [stn_pkg::IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [stn_pkg::IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [stn_pkg::RANK_W-1:0]  my_rank = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [stn_pkg::RANK_W-1:0]  child_id;
    logic [stn_pkg::SIZE_W-1:0]  child_blocks;
    logic [stn_pkg::RANK_W-1:0]  parent_id;
    logic                        has_parent;
    logic [stn_pkg::SIZE_W-1:0]  own_blocks;
    logic                        rank_error;
    logic                        last;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [stn_pkg::IDX_W-1:0]   cfg_index = '0;
    logic [stn_pkg::RATIO_W-1:0] cfg_data = '0;
    int                          pending;
    int                          errors;

    // When set, neither side inserts gaps or stalls.
    bit quiet = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    split_tree_neighbors #(
        .MAX_GROUP(MAX_GROUP)
    ) i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_my_rank     (my_rank),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_child_id    (child_id),
        .o_child_blocks(child_blocks),
        .o_parent_id   (parent_id),
        .o_has_parent  (has_parent),
        .o_own_blocks  (own_blocks),
        .o_rank_error  (rank_error),
        .o_last        (last),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    split_tree_neighbors_checker #(
        .MAX_GROUP(MAX_GROUP)
    ) i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_my_rank     (my_rank),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_child_id    (child_id),
        .i_child_blocks(child_blocks),
        .i_parent_id   (parent_id),
        .i_has_parent  (has_parent),
        .i_own_blocks  (own_blocks),
        .i_rank_error  (rank_error),
        .i_last        (last),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_pending     (pending),
        .o_errors      (errors)
    );

    // Valid stays high after an accepted item so that a back-to-back item needs no toggle.
    task automatic query(input int rank);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        my_rank  <= stn_pkg::RANK_W'(rank);
        do @(posedge clk); while (in_stall);
    endtask

    task automatic write_reg(input logic [stn_pkg::IDX_W-1:0] idx,
                             input logic [stn_pkg::RATIO_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Upper data bits of the group size write are random; the block keeps only the low bits.
    task automatic set_regs(input int group, input int ratio);
        if ($urandom_range(0, 1))
            write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                      stn_pkg::RATIO_W'($urandom_range(0, 131071)));
        write_reg(stn_pkg::CFG_GROUP_SIZE,
                  {10'($urandom_range(0, 1023)), stn_pkg::SIZE_W'(group)});
        write_reg(stn_pkg::CFG_SPLIT_RATIO, stn_pkg::RATIO_W'(ratio));
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial begin : stall_gen
        int hold;
        forever begin
            hold = quiet ? 0 : $urandom_range(0, 10);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin : watchdog
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        int queries_sent;
        int group;
        int ratio;
        int eff;
        int count;
        int rank;
        queries_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings first, then the corners of both registers.
        query(0);
        query(63);
        query(37);
        settle();
        set_regs(1, 32768);
        query(0);
        query(1);
        query(63);
        settle();
        // A zero group size acts as one rank.
        set_regs(0, 0);
        query(0);
        query(5);
        settle();
        set_regs(64, 0);
        query(0);
        query(63);
        query(1);
        settle();
        set_regs(64, 65536);
        query(0);
        query(63);
        query(62);
        settle();
        // Oversized group saturates and a ratio above one clips like any other.
        set_regs(127, 131071);
        query(0);
        query(63);
        query(20);
        settle();
        set_regs(2, 1);
        query(0);
        query(1);
        query(2);
        settle();
        set_regs(65, 16384);
        query(40);
        settle();

        while (queries_sent < QUERY_TARGET) begin
            quiet = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0:       group = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
                1:       group = $urandom_range(1, 2);
                2:       group = 64;
                default: group = $urandom_range(1, 64);
            endcase
            case ($urandom_range(0, 5))
                0:       ratio = $urandom_range(0, 131071);
                1:       ratio = $urandom_range(0, 3000);
                2:       ratio = $urandom_range(28000, 37000);
                3:       ratio = $urandom_range(0, 1) ? 65536 : 0;
                default: ratio = $urandom_range(0, 65535);
            endcase
            set_regs(group, ratio);
            eff = (group == 0) ? 1 : (group > MAX_GROUP) ? MAX_GROUP : group;
            count = $urandom_range(8, 40);
            for (int i = 0; i < count && queries_sent < QUERY_TARGET; i++) begin
                if ($urandom_range(0, 6) == 0)
                    rank = $urandom_range(0, 63);
                else if ($urandom_range(0, 4) == 0)
                    rank = 0;
                else
                    rank = $urandom_range(0, eff - 1);
                query(rank);
                queries_sent++;
            end
            settle();
        end

        if (errors == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/stn_pkg.sv
rtl/stn_split_unit.sv
rtl/split_tree_neighbors.sv
tb/sv/split_tree_neighbors_checker.sv
tb/sv/tb_split_tree_neighbors.sv
